[hw/rtl/u2rd_pkg.sv]
// Package for the unsigned-to-radix-digits unit: item types and numeral mapping.
// No dependencies.
`default_nettype none
package u2rd_pkg;

  localparam int unsigned ValueFieldBits = 64;
  localparam int unsigned RadixBits      = 6;
  localparam int unsigned CharBits       = 7;

  localparam logic [RadixBits-1:0] RadixMin     = 6'd2;
  localparam logic [RadixBits-1:0] RadixMax     = 6'd36;
  localparam logic [RadixBits-1:0] RadixDefault = 6'd10;
  localparam logic [RadixBits-1:0] DecimalSpan  = 6'd10;

  localparam logic [CharBits-1:0] CharZero = 7'd48;  // '0'
  localparam logic [CharBits-1:0] CharA    = 7'd97;  // 'a'

  typedef struct packed {
    logic [ValueFieldBits-1:0] value;
    logic [RadixBits-1:0]      radix;
  } in_item_t;

  typedef struct packed {
    logic [CharBits-1:0] digit_char;
    logic                last;
  } out_item_t;

  // Digit 0..35 to ASCII: '0'-'9', then 'a'-'z'
  function automatic logic [CharBits-1:0] numeral_of(input logic [RadixBits-1:0] d);
    logic [CharBits-1:0] dx;
    dx = {1'b0, d};
    if (d < DecimalSpan) begin
      numeral_of = CharZero + dx;
    end else begin
      numeral_of = CharA + dx - {1'b0, DecimalSpan};
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/unsigned_to_radix_digits_unit.sv]
// Top level of the unsigned-to-radix-digits unit: bit-serial divider, digit stack, output reg.
// Depends on u2rd_pkg.
`default_nettype none
// Each digit costs one pass of the one-bit-per-cycle restoring divider over VALUE_BITS bits;
//   the unit takes no new item until every digit of the last one has been sent out.
// Digits then leave one per cycle while the output is not stalled, most significant first,
// from a shift-register stack.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops any output item.
module unsigned_to_radix_digits_unit
  import u2rd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned BitCntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned DigCntW = $clog2(VALUE_BITS + 1);
  localparam int unsigned RemW    = RadixBits + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic                  qnz_q, qnz_d;
  logic [VALUE_BITS-1:0] dv_q, dv_d;
  logic [RadixBits-1:0]  rem_q, rem_d;
  logic [RadixBits-1:0]  radix_q, radix_d;
  logic [RadixBits-1:0]  stack_q [VALUE_BITS];
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  in_acc;
  logic                  push;
  logic                  pop;
  logic [RemW-1:0]       trial;
  logic                  qbit;
  logic [RemW-1:0]       rem_next;
  logic                  out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // One restoring-division step: shift in dividend MSB, subtract radix if it fits
  assign trial    = {rem_q, dv_q[VALUE_BITS-1]};
  assign qbit     = (trial >= {1'b0, radix_q});
  assign rem_next = qbit ? (trial - {1'b0, radix_q}) : trial;

  // Controller
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    qnz_d       = qnz_q;
    dv_d        = dv_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    push        = 1'b0;
    pop         = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          dv_d      = in_item_i.value[VALUE_BITS-1:0];
          rem_d     = '0;
          qnz_d     = 1'b0;
          bit_cnt_d = '0;
          dig_cnt_d = '0;
          if (in_item_i.radix inside {[RadixMin:RadixMax]}) begin
            radix_d = in_item_i.radix;
          end else begin
            radix_d = RadixDefault;
          end
          state_d = StDiv;
        end
      end
      StDiv: begin
        dv_d      = {dv_q[VALUE_BITS-2:0], qbit};
        rem_d     = rem_next[RadixBits-1:0];
        qnz_d     = qnz_q | qbit;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(VALUE_BITS - 1)) begin
          // Pass done: remainder is the next digit, quotient feeds the next pass
          push      = 1'b1;
          dig_cnt_d = dig_cnt_q + 1'b1;
          bit_cnt_d = '0;
          rem_d     = '0;
          qnz_d     = 1'b0;
          if (!(qnz_q | qbit)) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          pop                   = 1'b1;
          out_valid_d           = 1'b1;
          out_item_d.digit_char = numeral_of(stack_q[0]);
          out_item_d.last       = (dig_cnt_q == DigCntW'(1));
          dig_cnt_d             = dig_cnt_q - 1'b1;
          if (dig_cnt_q == DigCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      qnz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      qnz_q       <= qnz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dv_q       <= dv_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    out_item_q <= out_item_d;
  end

  // Digit stack: push shifts toward the bottom, pop shifts toward the top
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[0] <= rem_next[RadixBits-1:0];
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

endmodule
`default_nettype wire
